// ===== sv/mst_pkg.sv =====
// Shared types and constants for the multi-slot one-shot timer.
// Used by mst_front, mst_back and the top level; depends on nothing.
package mst_pkg;

   // Command codes carried by req_cmd
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_ACCEPT = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_EXPIRY = 2'd2;

   // Fixed field widths
   localparam int DELAY_W   = 16;
   localparam int HANDLER_W = 8;
   localparam int JOB_W     = 32;
   localparam int SENDER_W  = 48;
   localparam int SLOT_W    = 4;
   localparam int PAYLOAD_W = HANDLER_W + JOB_W + SENDER_W;

   // At most this many expiry transactions per tick
   localparam int MAX_RESULTS = 16;
   localparam int EMIT_W      = 5;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = QPTR_W + 1;

   typedef struct packed {
      logic [1:0]           status;
      logic [SLOT_W-1:0]    slot;
      logic [HANDLER_W-1:0] handler;
      logic [JOB_W-1:0]     job;
      logic [SENDER_W-1:0]  sender;
      logic                 last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_PREP,
      ST_SWEEP,
      ST_FLUSH
   } back_state_type;

endpackage

// ===== sv/mst_front.sv =====
// Front end of the timer pool: takes request transactions, saturates the delay
// to the count width and queues them for the slot engine. Uses mst_pkg.
module mst_front #(
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [mst_pkg::DELAY_W-1:0]     req_delay_ms,
   input  logic [mst_pkg::HANDLER_W-1:0]   req_handler_id,
   input  logic [mst_pkg::JOB_W-1:0]       req_job_tag,
   input  logic [mst_pkg::SENDER_W-1:0]    req_sender_tag,
   output logic                            q_valid,
   input  logic                            q_pop,
   output logic                            q_cmd,
   output logic [COUNT_BITS-1:0]           q_count,
   output logic [mst_pkg::HANDLER_W-1:0]   q_handler,
   output logic [mst_pkg::JOB_W-1:0]       q_job,
   output logic [mst_pkg::SENDER_W-1:0]    q_sender
);

   localparam int WIDE_W  = (COUNT_BITS > mst_pkg::DELAY_W) ? COUNT_BITS : mst_pkg::DELAY_W;
   localparam int ENTRY_W = 1 + COUNT_BITS + mst_pkg::PAYLOAD_W;

   logic [ENTRY_W-1:0]             fifo_ff [mst_pkg::QUEUE_DEPTH];
   logic [mst_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mst_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mst_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                           push;
   logic [WIDE_W-1:0]              delay_wide;
   logic [WIDE_W-1:0]              cnt_max_wide;
   logic [COUNT_BITS-1:0]          sat_count;
   logic [ENTRY_W-1:0]             head;

   // delay saturates when the count is narrower than the field
   assign delay_wide   = WIDE_W'(req_delay_ms);
   assign cnt_max_wide = WIDE_W'({COUNT_BITS{1'b1}});
   assign sat_count    = (delay_wide > cnt_max_wide) ? COUNT_BITS'(cnt_max_wide)
                                                     : COUNT_BITS'(delay_wide);

   assign req_ready = (count_ff != mst_pkg::QCNT_W'(mst_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + mst_pkg::QCNT_W'(push) - mst_pkg::QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= {req_cmd, sat_count, req_handler_id, req_job_tag, req_sender_tag};
      end
   end

   assign head      = fifo_ff[rd_ptr_ff];
   assign q_cmd     = head[ENTRY_W-1];
   assign q_count   = head[ENTRY_W-2 -: COUNT_BITS];
   assign q_handler = head[mst_pkg::PAYLOAD_W-1 -: mst_pkg::HANDLER_W];
   assign q_job     = head[mst_pkg::SENDER_W +: mst_pkg::JOB_W];
   assign q_sender  = head[mst_pkg::SENDER_W-1:0];

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue fill count did not follow a lone push");

endmodule

// ===== sv/mst_back.sv =====
// Slot engine of the timer pool: claims slots for starts, sweeps slots on ticks
// and drives the registered result stage. Uses mst_pkg.
module mst_back #(
   parameter int NUM_SLOTS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  logic                            q_cmd,
   input  logic [COUNT_BITS-1:0]           q_count,
   input  logic [mst_pkg::HANDLER_W-1:0]   q_handler,
   input  logic [mst_pkg::JOB_W-1:0]       q_job,
   input  logic [mst_pkg::SENDER_W-1:0]    q_sender,
   output mst_pkg::rsp_type                rsp_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam int ENT_W = COUNT_BITS + mst_pkg::PAYLOAD_W;

   // slot memory: {count, handler, job, sender}
   logic [ENT_W-1:0]                slot_mem [NUM_SLOTS];
   logic [ENT_W-1:0]                slot_rd_ff;
   logic [IDX_W-1:0]                rd_addr;
   logic                            mem_we;
   logic [ENT_W-1:0]                mem_wdata;

   mst_pkg::back_state_type         state_ff, state_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [NUM_SLOTS-1:0]            active_ff, active_in;
   logic                            pend_valid_ff, pend_valid_in;
   mst_pkg::rsp_type                pend_ff, pend_in;
   logic [mst_pkg::EMIT_W-1:0]      n_emit_ff, n_emit_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   mst_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            out_free;
   logic [COUNT_BITS-1:0]           rd_count;
   logic [mst_pkg::HANDLER_W-1:0]   rd_handler;
   logic [mst_pkg::JOB_W-1:0]       rd_job;
   logic [mst_pkg::SENDER_W-1:0]    rd_sender;
   logic                            slot_hit;
   logic                            fire;
   logic                            emit_slot;
   logic                            stall;
   logic                            advance;
   logic                            claim;
   logic [IDX_W-1:0]                next_idx;
   logic [mst_pkg::SLOT_W-1:0]      slot_code;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rd_count   = slot_rd_ff[ENT_W-1 -: COUNT_BITS];
   assign rd_handler = slot_rd_ff[mst_pkg::PAYLOAD_W-1 -: mst_pkg::HANDLER_W];
   assign rd_job     = slot_rd_ff[mst_pkg::SENDER_W +: mst_pkg::JOB_W];
   assign rd_sender  = slot_rd_ff[mst_pkg::SENDER_W-1:0];
   assign slot_hit   = active_ff[idx_ff];
   assign fire       = slot_hit && (rd_count == '0);
   assign emit_slot  = fire && (n_emit_ff < mst_pkg::EMIT_W'(mst_pkg::MAX_RESULTS));
   assign stall      = emit_slot && pend_valid_ff && !out_free;
   assign next_idx   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign slot_code  = mst_pkg::SLOT_W'(idx_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      n_emit_in     = n_emit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_wdata     = {rd_count - 1'b1, rd_handler, rd_job, rd_sender};
      rd_addr       = idx_ff;
      advance       = 1'b0;
      claim         = 1'b0;

      case (state_ff)
         mst_pkg::ST_IDLE: begin
            if (q_valid) begin
               idx_in = '0;
               if (q_cmd == mst_pkg::CMD_START) begin
                  state_in = mst_pkg::ST_FIND;
               end else begin
                  q_pop         = 1'b1;
                  pend_valid_in = 1'b0;
                  n_emit_in     = '0;
                  state_in      = mst_pkg::ST_PREP;
               end
            end
         end

         // scan for the lowest free slot, one slot per cycle; holds on a busy output
         mst_pkg::ST_FIND: begin
            if (!slot_hit) begin
               if (out_free) begin
                  claim             = 1'b1;
                  mem_we            = 1'b1;
                  mem_wdata         = {q_count, q_handler, q_job, q_sender};
                  active_in[idx_ff] = 1'b1;
                  rsp_valid_in      = 1'b1;
                  rsp_in            = '{mst_pkg::STATUS_ACCEPT, slot_code, '0, '0, '0, 1'b1};
                  q_pop             = 1'b1;
                  state_in          = mst_pkg::ST_IDLE;
               end
            end else if (idx_ff == LAST_IDX) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{mst_pkg::STATUS_REJECT, '0, '0, '0, '0, 1'b1};
                  q_pop        = 1'b1;
                  state_in     = mst_pkg::ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // slot 0 read is in flight
         mst_pkg::ST_PREP: begin
            state_in = mst_pkg::ST_SWEEP;
         end

         // one slot per cycle unless an expiry is blocked; the newest expiry is
         // held back so the final one can carry the last marker
         mst_pkg::ST_SWEEP: begin
            if (!stall) begin
               advance = 1'b1;
               rd_addr = next_idx;
               idx_in  = next_idx;
               if (fire) begin
                  active_in[idx_ff] = 1'b0;
                  if (emit_slot) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = pend_ff;
                     end
                     pend_in = '{mst_pkg::STATUS_EXPIRY, slot_code, rd_handler, rd_job,
                                 rd_sender, 1'b0};
                     pend_valid_in = 1'b1;
                     n_emit_in     = n_emit_ff + 1'b1;
                  end
               end else if (slot_hit) begin
                  mem_we = 1'b1;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = mst_pkg::ST_FLUSH;
               end
            end
         end

         mst_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = mst_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = mst_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mst_pkg::ST_IDLE;
         idx_ff        <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
         n_emit_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
         n_emit_ff     <= n_emit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[idx_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      slot_rd_ff <= slot_mem[rd_addr];
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   a_claim_sets_active: assert property (@(posedge clock) disable iff (reset)
      claim |=> active_ff[$past(idx_ff)])
      else $error("claimed slot not marked active");

   a_sweep_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mst_pkg::ST_SWEEP && !advance) |-> (pend_valid_ff && !out_free))
      else $error("sweep stalled without a blocked expiry");

   a_emit_cap: assert property (@(posedge clock) disable iff (reset)
      n_emit_ff <= mst_pkg::EMIT_W'(mst_pkg::MAX_RESULTS))
      else $error("expiry count beyond cap");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mst_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("held expiry left behind after a tick");

   a_pop_has_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty command queue");

endmodule

// ===== sv/multi_slot_oneshot_timer.sv =====
// Top level of the multi-slot one-shot timer pool.
// Instantiates mst_front and mst_back; uses mst_pkg.
// Usage:
//  - req_* channel (valid/ready): one transaction per command. req_cmd = start
//    claims the lowest free slot with req_delay_ms, req_handler_id,
//    req_job_tag and req_sender_tag; req_cmd = tick ages every active slot.
//  - rsp_* channel (valid/ready): a start always returns one transaction
//    (accepted with its slot, or rejected when the pool is full). A tick
//    returns one expiry per slot whose count had reached zero, in ascending
//    slot order, capped at 16, with rsp_last on the final one; a tick that
//    fires nothing returns nothing. A slot fires on the (delay+1)-th tick.
//  - Flow: a two-entry command queue decouples intake from the slot engine.
//    The engine visits one slot per cycle unless its result is blocked: a
//    start runs the free-slot scan, a tick fills the read pipeline, sweeps
//    the slots and flushes the held final expiry. A start's result passes
//    the queue, the idle and find states and the result register.
//  - rsp_ready low holds the result register; a tick sweep then pauses on the
//    next expiry, and once the queue fills req_ready drops.
//  - Reset (synchronous, active high) frees all slots and empties the queue;
//    slot contents are not cleared, as they are written before use.
module multi_slot_oneshot_timer #(
   parameter int NUM_SLOTS  = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [mst_pkg::DELAY_W-1:0]     req_delay_ms,
   input  logic [mst_pkg::HANDLER_W-1:0]   req_handler_id,
   input  logic [mst_pkg::JOB_W-1:0]       req_job_tag,
   input  logic [mst_pkg::SENDER_W-1:0]    req_sender_tag,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [mst_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [mst_pkg::HANDLER_W-1:0]   rsp_out_handler,
   output logic [mst_pkg::JOB_W-1:0]       rsp_out_job,
   output logic [mst_pkg::SENDER_W-1:0]    rsp_out_sender,
   output logic                            rsp_last
);

   logic                            q_valid;
   logic                            q_pop;
   logic                            q_cmd;
   logic [COUNT_BITS-1:0]           q_count;
   logic [mst_pkg::HANDLER_W-1:0]   q_handler;
   logic [mst_pkg::JOB_W-1:0]       q_job;
   logic [mst_pkg::SENDER_W-1:0]    q_sender;
   mst_pkg::rsp_type                rsp_data;

   // intake and command queue
   mst_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_delay_ms   (req_delay_ms),
      .req_handler_id (req_handler_id),
      .req_job_tag    (req_job_tag),
      .req_sender_tag (req_sender_tag),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_cmd          (q_cmd),
      .q_count        (q_count),
      .q_handler      (q_handler),
      .q_job          (q_job),
      .q_sender       (q_sender)
   );

   // slot engine with registered result stage
   mst_back #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd),
      .q_count   (q_count),
      .q_handler (q_handler),
      .q_job     (q_job),
      .q_sender  (q_sender),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   assign rsp_status      = rsp_data.status;
   assign rsp_slot        = rsp_data.slot;
   assign rsp_out_handler = rsp_data.handler;
   assign rsp_out_job     = rsp_data.job;
   assign rsp_out_sender  = rsp_data.sender;
   assign rsp_last        = rsp_data.last;

endmodule

// ===== bench/multi_slot_oneshot_timer_test.sv =====
// Self-checking bench for multi_slot_oneshot_timer: directed and random start/tick traffic
// with an in-bench model of the slot pool. Depends on mst_pkg and the RTL under sv/.
module multi_slot_oneshot_timer_test;

   localparam int NUM_SLOTS   = 16;
   localparam int CLK_PERIOD  = 10;
   localparam int HOLD_CYCLES = 300;     // long receiver back-pressure stretch
   localparam int HOLD_AFTER  = 60;      // starts once this many commands went in
   localparam int DRAIN_SPAN  = 55;      // every so often a command waits for an empty pipe
   localparam int DRAIN_PHASE = 30;
   localparam int RANDOM_LEN  = 127;
   localparam int MAX_REPORTS = 40;

   // One command as the sender sees it, plus its pacing
   typedef struct {
      logic                          cmd;
      logic [mst_pkg::DELAY_W-1:0]   delay;
      logic [mst_pkg::HANDLER_W-1:0] handler;
      logic [mst_pkg::JOB_W-1:0]     job;
      logic [mst_pkg::SENDER_W-1:0]  sender;
      int                            gap;      // idle cycles after this one is taken
      bit                            drain;    // hold back until every result is in
   } timer_cmd_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_cmd = mst_pkg::CMD_TICK;
   logic [mst_pkg::DELAY_W-1:0]   req_delay_ms = '0;
   logic [mst_pkg::HANDLER_W-1:0] req_handler_id = '0;
   logic [mst_pkg::JOB_W-1:0]     req_job_tag = '0;
   logic [mst_pkg::SENDER_W-1:0]  req_sender_tag = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic [mst_pkg::SLOT_W-1:0]    rsp_slot;
   logic [mst_pkg::HANDLER_W-1:0] rsp_out_handler;
   logic [mst_pkg::JOB_W-1:0]     rsp_out_job;
   logic [mst_pkg::SENDER_W-1:0]  rsp_out_sender;
   logic                          rsp_last;

   // Bench-side copy of the slot pool
   bit                            pool_busy    [NUM_SLOTS];
   logic [15:0]                   pool_left    [NUM_SLOTS];
   logic [mst_pkg::HANDLER_W-1:0] pool_handler [NUM_SLOTS];
   logic [mst_pkg::JOB_W-1:0]     pool_job     [NUM_SLOTS];
   logic [mst_pkg::SENDER_W-1:0]  pool_sender  [NUM_SLOTS];

   timer_cmd_type     queued_cmds[$];        // commands waiting for the driver
   mst_pkg::rsp_type  due_responses[$];      // results the pool owes, oldest first
   timer_cmd_type     cur_cmd;
   int         send_wait = 0;
   int         recv_wait = 0;
   bit         long_hold = 1'b0;
   int         cmds_total = 0;
   int         cmds_done = 0;
   int         rsps_seen = 0;
   int         err_count = 0;
   int         n_starts = 0;
   int         n_ticks = 0;
   int         n_expiries = 0;
   int         n_rejects = 0;

   multi_slot_oneshot_timer #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COUNT_BITS (16)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_delay_ms    (req_delay_ms),
      .req_handler_id  (req_handler_id),
      .req_job_tag     (req_job_tag),
      .req_sender_tag  (req_sender_tag),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_out_handler (rsp_out_handler),
      .rsp_out_job     (rsp_out_job),
      .rsp_out_sender  (rsp_out_sender),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one accepted command to the pool copy and queue what it must produce.
   // Start: lowest free slot, or reject with slot 0 when all are busy.
   // Tick: ascending sweep; zero count fires and frees, otherwise count down.
   function automatic void advance_timer_pool(timer_cmd_type c);
      mst_pkg::rsp_type r;
      int      first_new;
      int      fired;
      first_new = due_responses.size();
      fired     = 0;
      r         = '0;
      if (c.cmd == mst_pkg::CMD_START) begin
         r.status = mst_pkg::STATUS_REJECT;
         r.last   = 1'b1;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!pool_busy[i]) begin
               pool_busy[i]    = 1'b1;
               pool_left[i]    = c.delay;
               pool_handler[i] = c.handler;
               pool_job[i]     = c.job;
               pool_sender[i]  = c.sender;
               r.status        = mst_pkg::STATUS_ACCEPT;
               r.slot          = i[mst_pkg::SLOT_W-1:0];
               break;
            end
         end
         due_responses.push_back(r);
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pool_busy[i]) begin
               if (pool_left[i] == 0) begin
                  r.status  = mst_pkg::STATUS_EXPIRY;
                  r.slot    = i[mst_pkg::SLOT_W-1:0];
                  r.handler = pool_handler[i];
                  r.job     = pool_job[i];
                  r.sender  = pool_sender[i];
                  r.last    = 1'b0;
                  if (fired < mst_pkg::MAX_RESULTS) begin
                     due_responses.push_back(r);
                     fired++;
                  end
                  pool_busy[i] = 1'b0;
               end else begin
                  pool_left[i] = pool_left[i] - 16'd1;
               end
            end
         end
         // only the final expiry of the sweep carries last
         if (fired != 0)
            due_responses[first_new + fired - 1].last = 1'b1;
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      err_count++;
      if (err_count <= MAX_REPORTS)
         $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
   endtask

   task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Sender pacing: stretches of back-to-back traffic, otherwise random idle gaps
   task automatic queue_cmd(logic cmd, logic [mst_pkg::DELAY_W-1:0] delay,
                            logic [mst_pkg::HANDLER_W-1:0] handler,
                            logic [mst_pkg::JOB_W-1:0] job,
                            logic [mst_pkg::SENDER_W-1:0] sender);
      timer_cmd_type c;
      c.cmd     = cmd;
      c.delay   = delay;
      c.handler = handler;
      c.job     = job;
      c.sender  = sender;
      c.gap     = (cmds_total % 50 < 15) ? 0 : $urandom_range(0, 3);
      c.drain   = (cmds_total % DRAIN_SPAN == DRAIN_PHASE);
      queued_cmds.push_back(c);
      cmds_total++;
   endtask

   task automatic queue_start(logic [mst_pkg::DELAY_W-1:0] delay);
      queue_cmd(mst_pkg::CMD_START, delay, mst_pkg::HANDLER_W'($urandom), $urandom,
                mst_pkg::SENDER_W'({$urandom, $urandom}));
   endtask

   task automatic queue_tick();
      queue_cmd(mst_pkg::CMD_TICK, mst_pkg::DELAY_W'($urandom),
                mst_pkg::HANDLER_W'($urandom), $urandom,
                mst_pkg::SENDER_W'({$urandom, $urandom}));
   endtask

   // Driver: one command per transaction; payload held until accepted
   always @(posedge clock) begin
      timer_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait <= 0;
      end else begin
         if (req_valid && req_ready) begin
            advance_timer_pool(cur_cmd);
            if (cur_cmd.cmd == mst_pkg::CMD_START)
               n_starts++;
            else
               n_ticks++;
            cmds_done++;
         end
         if (req_valid && !req_ready) begin
            // still offered, keep everything as is
         end else if (send_wait != 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (queued_cmds.size() != 0 &&
                      !(queued_cmds[0].drain && due_responses.size() != 0)) begin
            nxt = queued_cmds.pop_front();
            cur_cmd        <= nxt;
            req_valid      <= 1'b1;
            req_cmd        <= nxt.cmd;
            req_delay_ms   <= nxt.delay;
            req_handler_id <= nxt.handler;
            req_job_tag    <= nxt.job;
            req_sender_tag <= nxt.sender;
            send_wait      <= nxt.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result transaction against the oldest one owed,
   // and pace rsp_ready (random stalls, calm stretches, the long hold).
   always @(posedge clock) begin
      mst_pkg::rsp_type want;
      int      w;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsps_seen++;
            if (rsp_status == mst_pkg::STATUS_EXPIRY)
               n_expiries++;
            if (rsp_status == mst_pkg::STATUS_REJECT)
               n_rejects++;
            if (due_responses.size() == 0) begin
               report_mismatch("unsolicited result status", 64'(rsp_status), '0);
            end else begin
               want = due_responses.pop_front();
               compare_field("status", 64'(rsp_status), 64'(want.status));
               compare_field("slot", 64'(rsp_slot), 64'(want.slot));
               compare_field("out_handler", 64'(rsp_out_handler), 64'(want.handler));
               compare_field("out_job", 64'(rsp_out_job), 64'(want.job));
               compare_field("out_sender", 64'(rsp_out_sender), 64'(want.sender));
               compare_field("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (long_hold) begin
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            w = (rsps_seen % 64 < 20) ? 0 : $urandom_range(0, 3);
            rsp_ready <= (w == 0);
            recv_wait <= w;
         end else if (recv_wait != 0) begin
            rsp_ready <= (recv_wait == 1);
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver stall: results back up, the command queue fills, req_ready drops
   initial begin
      while (cmds_done < HOLD_AFTER) @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Stimulus and end of run
   initial begin
      int pick;
      int burst;
      // directed: quiet tick on an empty pool
      queue_tick();
      // fill all slots with zero delay; slot 0 gets all-ones payload
      queue_cmd(mst_pkg::CMD_START, '0, '1, '1, '1);
      for (int i = 1; i < NUM_SLOTS; i++)
         queue_start('0);
      // pool full: rejected start
      queue_cmd(mst_pkg::CMD_START, '1, '1, '0, '1);
      // every slot fires in one sweep
      queue_tick();
      // longest delay with zero payload; this slot stays busy for the run
      queue_cmd(mst_pkg::CMD_START, '1, '0, '0, '0);
      queue_start(16'd1);
      queue_tick();   // counts down only, nothing fires
      queue_tick();   // delay 1 fires on the second tick
      // random: bursts of starts to reach a full pool, single starts, runs of ticks
      while (cmds_total < cmds_total + 1 && queued_cmds.size() < 23 + RANDOM_LEN) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            burst = $urandom_range(4, 14);
            repeat (burst) queue_start(($urandom_range(0, 9) < 7) ?
                                       16'($urandom_range(0, 4)) : 16'($urandom_range(0, 40)));
         end else if (pick < 6) begin
            queue_start(($urandom_range(0, 9) < 7) ?
                        16'($urandom_range(0, 4)) : 16'($urandom_range(0, 40)));
         end else begin
            burst = $urandom_range(1, 6);
            repeat (burst) queue_tick();
         end
      end
      while (cmds_done < cmds_total) @(posedge clock);
      while (due_responses.size() != 0) @(posedge clock);
      repeat (4 * NUM_SLOTS) @(posedge clock);
      $display("Ran %0d starts (%0d rejected on a full pool) and %0d ticks,",
               n_starts, n_rejects, n_ticks);
      $display("checked %0d result transactions, %0d of them expiries.",
               rsps_seen, n_expiries);
      if (err_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #(CLK_PERIOD * 200000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
